>>> rtl/round_robin_quantum_scheduler_core_macros.svh
// Assertion helpers shared by the scheduler RTL.
// Every check samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_CORE_MACROS_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_CORE_MACROS_SVH

// The property must hold in the same cycle.
`define RRQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/rrqs_pkg.sv
`default_nettype none

package rrqs_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int ID_W   = 8;
  localparam int LEFT_W = 16;
  localparam int Q_W    = 8;

  localparam logic [Q_W-1:0] QUANTUM_RST = 8'd4;
  localparam logic [Q_W-1:0] QUANTUM_MIN = 8'd1;

  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  // What the chain of cells does on each clock.
  typedef enum logic [2:0] {
    CM_HOLD,    // every cell keeps its job
    CM_INSERT,  // open a gap at pos and load the new job there
    CM_REMOVE,  // drop cell 0 and close the gap
    CM_ROTATE,  // move cell 0 to pos, cells 1..pos shift toward cell 0
    CM_UPDATE   // rewrite cell 0 in place
  } chain_mode_t;

endpackage

`default_nettype wire

>>> rtl/rrqs_cell.sv
`default_nettype none

// One ring slot. It holds a job id and its remaining work and can take the
// job of either neighbor or the value on the shared load bus.
module rrqs_cell #(
  parameter int IDX = 0,
  parameter int AW  = 4
) (
  input  wire                                   clk,
  input  wire  rrqs_pkg::chain_mode_t           mode,
  input  wire  [AW-1:0]                         pos,
  input  wire  [rrqs_pkg::ID_W-1:0]             load_id,
  input  wire  [rrqs_pkg::LEFT_W-1:0]           load_left,
  input  wire  [rrqs_pkg::ID_W-1:0]             prev_id,
  input  wire  [rrqs_pkg::LEFT_W-1:0]           prev_left,
  input  wire  [rrqs_pkg::ID_W-1:0]             next_id,
  input  wire  [rrqs_pkg::LEFT_W-1:0]           next_left,
  output logic [rrqs_pkg::ID_W-1:0]             id_r,
  output logic [rrqs_pkg::LEFT_W-1:0]           left_r
);

  localparam logic [AW-1:0] MY_POS = AW'(IDX);

  logic [rrqs_pkg::ID_W-1:0]   id_nxt;
  logic [rrqs_pkg::LEFT_W-1:0] left_nxt;

  always_comb begin
    id_nxt   = id_r;
    left_nxt = left_r;
    unique case (mode)
      rrqs_pkg::CM_HOLD: begin
      end
      rrqs_pkg::CM_INSERT: begin
        if (pos == MY_POS) begin
          id_nxt   = load_id;
          left_nxt = load_left;
        end else if (pos < MY_POS) begin
          id_nxt   = prev_id;
          left_nxt = prev_left;
        end
      end
      rrqs_pkg::CM_REMOVE: begin
        id_nxt   = next_id;
        left_nxt = next_left;
      end
      rrqs_pkg::CM_ROTATE: begin
        if (MY_POS < pos) begin
          id_nxt   = next_id;
          left_nxt = next_left;
        end else if (pos == MY_POS) begin
          id_nxt   = load_id;
          left_nxt = load_left;
        end
      end
      rrqs_pkg::CM_UPDATE: begin
        if (IDX == 0) begin
          id_nxt   = load_id;
          left_nxt = load_left;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    left_r <= left_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/round_robin_quantum_scheduler_core.sv
`default_nettype none
`include "round_robin_quantum_scheduler_core_macros.svh"

// Time-sliced round-robin scheduler. An arrival beat (in_kind = 0) appends a job
// id and its service time at the tail of the ring; it is refused when the ring
// is full or the service time is zero. A tick beat (in_kind = 1) runs the active
// job for one unit: a finished job leaves the ring and its successor starts with
// a fresh quantum, and a job whose quantum runs out hands over to the next job.
// The block takes a beat at every rising edge where start is high and busy is
// low; busy never rises, so one beat per clock is taken, and the single result
// beat appears on the out_ ports, marked by out_valid, in the cycle right after
// the accepting edge. The result is held for that one cycle only and the
// receiver cannot stall it, so it must be captured when out_valid is high.
// cfg_we writes the quantum (a value of zero is stored as one); a new quantum
// applies from the next fresh slice and must be written while no beat is in
// flight.
//
// Jobs live in a chain of MAX_ENTRIES identical cells. The chain is kept
// rotated so that cell 0 always holds the active job (or the head of the ring
// while no job is active). This keeps the critical path short: a tick reads
// and decrements cell 0 only, and every ring edit is a one-step neighbor move:
//  - finishing drops cell 0 and every cell takes the job of its upper neighbor,
//  - rotating moves cell 0 to the last occupied cell while the others step down,
//  - an arrival opens a gap at the logical tail, which sits at physical cell
//    (count - active position), and the cells above it step up.
// The logical index of the active job is tracked in apos_r so that the ring
// order seen from outside matches plain arrival order.
// The work for a beat is one 16-bit decrement and zero test on cell 0, the 8-bit slice
// decrement and the index compares that steer each cell, so a beat never needs to raise busy.
module round_robin_quantum_scheduler_core #(
  parameter int MAX_ENTRIES = rrqs_pkg::MAX_ENTRIES_DEF,
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // Item channel.
  input  wire                              start,
  output logic                             busy,
  input  wire                              in_kind,
  input  wire  [rrqs_pkg::ID_W-1:0]        in_job_id,
  input  wire  [rrqs_pkg::LEFT_W-1:0]      in_service_time,
  // Quantum register.
  input  wire                              cfg_we,
  input  wire  [rrqs_pkg::Q_W-1:0]         cfg_wdata,
  // Result channel.
  output logic                             out_valid,
  output logic                             out_accepted,
  output logic                             out_ran,
  output logic [rrqs_pkg::ID_W-1:0]        out_run_id,
  output logic [rrqs_pkg::LEFT_W-1:0]      out_remaining,
  output logic                             out_finished,
  output logic                             out_rotated,
  output logic [CW-1:0]                    out_occupancy
);

  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  // Control state.
  logic [CW-1:0]               cnt_r,     cnt_nxt;
  logic [AW-1:0]               apos_r,    apos_nxt;
  logic                        act_r,     act_nxt;
  logic [rrqs_pkg::Q_W-1:0]    slice_r,   slice_nxt;
  logic [rrqs_pkg::Q_W-1:0]    quantum_r, quantum_nxt;

  // Result registers.
  logic                        out_valid_nxt;
  logic                        out_accepted_nxt;
  logic                        out_ran_nxt;
  logic [rrqs_pkg::ID_W-1:0]   out_run_id_nxt;
  logic [rrqs_pkg::LEFT_W-1:0] out_remaining_nxt;
  logic                        out_finished_nxt;
  logic                        out_rotated_nxt;

  // Chain control and data.
  rrqs_pkg::chain_mode_t       mode;
  logic [AW-1:0]               pos;
  logic [rrqs_pkg::ID_W-1:0]   bus_id;
  logic [rrqs_pkg::LEFT_W-1:0] bus_left;
  logic [rrqs_pkg::ID_W-1:0]   cell_id   [MAX_ENTRIES];
  logic [rrqs_pkg::LEFT_W-1:0] cell_left [MAX_ENTRIES];

  logic                        in_fire;
  logic [rrqs_pkg::LEFT_W-1:0] rem;
  logic [rrqs_pkg::Q_W-1:0]    slice_cur;
  logic [rrqs_pkg::Q_W-1:0]    slice_dec;
  logic [CW-1:0]               apos_ext;

  // Every beat completes in the cycle it is taken.
  assign busy     = 1'b0;
  assign in_fire  = start & ~busy;
  assign rem      = cell_left[0] - rrqs_pkg::LEFT_W'(1);
  assign apos_ext = CW'(apos_r);

  // A fresh slice is loaded when no job was active yet.
  assign slice_cur = act_r ? slice_r : quantum_r;
  assign slice_dec = (slice_cur != '0) ? slice_cur - rrqs_pkg::Q_W'(1) : '0;

  always_comb begin
    cnt_nxt   = cnt_r;
    apos_nxt  = apos_r;
    act_nxt   = act_r;
    slice_nxt = slice_r;

    quantum_nxt = quantum_r;
    if (cfg_we) begin
      quantum_nxt = (cfg_wdata == '0) ? rrqs_pkg::QUANTUM_MIN : cfg_wdata;
    end

    mode     = rrqs_pkg::CM_HOLD;
    pos      = '0;
    bus_id   = in_job_id;
    bus_left = in_service_time;

    out_valid_nxt     = in_fire;
    out_accepted_nxt  = 1'b0;
    out_ran_nxt       = 1'b0;
    out_run_id_nxt    = '0;
    out_remaining_nxt = '0;
    out_finished_nxt  = 1'b0;
    out_rotated_nxt   = 1'b0;

    if (in_fire) begin
      if (in_kind == rrqs_pkg::KIND_ARRIVAL) begin
        if ((cnt_r != CNT_FULL) && (in_service_time != '0)) begin
          // The new tail goes just above the cell that holds the last job in arrival order.
          mode             = rrqs_pkg::CM_INSERT;
          pos              = AW'(cnt_r - apos_ext);
          cnt_nxt          = cnt_r + CNT_ONE;
          out_accepted_nxt = 1'b1;
        end
      end else if (cnt_r != '0) begin
        act_nxt           = 1'b1;
        out_ran_nxt       = 1'b1;
        out_run_id_nxt    = cell_id[0];
        out_remaining_nxt = rem;
        bus_id            = cell_id[0];
        bus_left          = rem;
        if (rem == '0) begin
          // The job is done: drop it, its successor slides into cell 0.
          out_finished_nxt = 1'b1;
          mode             = rrqs_pkg::CM_REMOVE;
          cnt_nxt          = cnt_r - CNT_ONE;
          slice_nxt        = quantum_r;
          if (cnt_nxt == '0) begin
            act_nxt  = 1'b0;
            apos_nxt = '0;
          end else begin
            apos_nxt = (apos_ext < cnt_nxt) ? apos_r : '0;
          end
        end else if (slice_dec == '0) begin
          // Slice used up: the active job goes to the back of the chain.
          out_rotated_nxt = 1'b1;
          mode            = rrqs_pkg::CM_ROTATE;
          pos             = AW'(cnt_r - CNT_ONE);
          apos_nxt        = ((apos_ext + CNT_ONE) < cnt_r) ? apos_r + AW'(1) : '0;
          slice_nxt       = quantum_r;
        end else begin
          mode      = rrqs_pkg::CM_UPDATE;
          slice_nxt = slice_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      apos_r    <= '0;
      act_r     <= 1'b0;
      slice_r   <= rrqs_pkg::QUANTUM_RST;
      quantum_r <= rrqs_pkg::QUANTUM_RST;
      out_valid <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      apos_r    <= apos_nxt;
      act_r     <= act_nxt;
      slice_r   <= slice_nxt;
      quantum_r <= quantum_nxt;
      out_valid <= out_valid_nxt;
    end
  end

  // Result payload needs no reset; out_valid qualifies it.
  always_ff @(posedge clk) begin
    out_accepted  <= out_accepted_nxt;
    out_ran       <= out_ran_nxt;
    out_run_id    <= out_run_id_nxt;
    out_remaining <= out_remaining_nxt;
    out_finished  <= out_finished_nxt;
    out_rotated   <= out_rotated_nxt;
    out_occupancy <= cnt_nxt;
  end

  // The chain. The end cells see their own job in place of a missing neighbor.
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    logic [rrqs_pkg::ID_W-1:0]   prev_id,  next_id;
    logic [rrqs_pkg::LEFT_W-1:0] prev_left, next_left;

    if (k == 0) begin : g_first
      assign prev_id   = cell_id[k];
      assign prev_left = cell_left[k];
    end else begin : g_inner_lo
      assign prev_id   = cell_id[k-1];
      assign prev_left = cell_left[k-1];
    end

    if (k == MAX_ENTRIES - 1) begin : g_last
      assign next_id   = cell_id[k];
      assign next_left = cell_left[k];
    end else begin : g_inner_hi
      assign next_id   = cell_id[k+1];
      assign next_left = cell_left[k+1];
    end

    rrqs_cell #(
      .IDX (k),
      .AW  (AW)
    ) u_cell (
      .clk       (clk),
      .mode      (mode),
      .pos       (pos),
      .load_id   (bus_id),
      .load_left (bus_left),
      .prev_id   (prev_id),
      .prev_left (prev_left),
      .next_id   (next_id),
      .next_left (next_left),
      .id_r      (cell_id[k]),
      .left_r    (cell_left[k])
    );
  end

  // A result beat follows every accepted item in the next cycle.
  `RRQS_ASSERT_NEXT(a_result_follows, in_fire, out_valid, "missing result beat")
  // A job cannot both finish and rotate on the same tick.
  `RRQS_ASSERT(a_fin_xor_rot, !(out_valid && out_finished && out_rotated), "finish and rotate")
  // A finish removes exactly one job from the ring.
  `RRQS_ASSERT(a_fin_count,
               (out_valid && out_finished) |-> (cnt_r == ($past(cnt_r) - CNT_ONE)),
               "finish did not shrink ring")
  // With no active job the chain stays aligned to the head of the ring.
  `RRQS_ASSERT(a_idle_aligned, !act_r |-> (apos_r == '0), "idle ring not head aligned")
  // The fill count never passes the chain length.
  `RRQS_ASSERT(a_cnt_bound, cnt_r <= CNT_FULL, "ring overfilled")

endmodule

`default_nettype wire
